// ===== rtl/core/rmq_pkg.sv =====
package rmq_pkg;

  localparam int FracBits = 14;
  localparam int RadW     = 19;                  // radicand, positive range
  localparam int SqW      = RadW + FracBits + 2; // 35-bit sqrt operand
  localparam int SW       = (SqW + 1) / 2;       // 18-bit root
  localparam int NumW     = 17;                  // off-diagonal numerator
  localparam int MagW     = NumW - 1 + 1;        // magnitude, 17 bits
  localparam int DivW     = MagW + FracBits;     // dividend, 31 bits
  localparam int QW       = DivW;                // quotient width

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_RX    = 2'd1;
  localparam logic [1:0] BR_UY    = 2'd2;
  localparam logic [1:0] BR_FZ    = 2'd3;

  typedef struct packed {
    logic              neg;
    logic [MagW-1:0]   mag;
  } num_t;

  typedef struct packed {
    logic [1:0]        branch;
    logic              invalid;
    num_t [2:0]        nums;
  } ctl_t;

  function automatic logic [15:0] sat16(input logic signed [QW+1:0] v);
    if (v > $signed((QW+2)'(32767))) sat16 = 16'h7fff;
    else if (v < -$signed((QW+2)'(32768))) sat16 = 16'h8000;
    else sat16 = v[15:0];
  endfunction

endpackage

// ===== rtl/core/rmq_front.sv =====
// Branch select, radicand and numerators. One register stage.
module rmq_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic signed [15:0]         rx, ry, rz, ux, uy, uz, fx, fy, fz,
  output logic                       out_valid,
  output logic [rmq_pkg::RadW-1:0]   rad,
  output rmq_pkg::ctl_t              ctl
);
  logic signed [18:0] trace, r;
  logic [1:0] br;
  logic signed [16:0] a, b, c, d;
  logic signed [16:0] n0, n1, n2;
  rmq_pkg::ctl_t c_next;

  function automatic rmq_pkg::num_t mk(input logic signed [16:0] n);
    mk.neg = n[16];
    mk.mag = n[16] ? 17'(-n) : 17'(n);
  endfunction

  always_comb begin
    trace = 19'(rx) + 19'(uy) + 19'(fz);
    a = 17'(uz) - 17'(fy);
    b = 17'(fx) - 17'(rz);
    c = 17'(ry) - 17'(ux);
    d = 17'(ux) + 17'(ry);
    if (trace > 0) begin
      br = rmq_pkg::BR_TRACE;
      r = 19'(1 << rmq_pkg::FracBits) + trace;
      n0 = a; n1 = b; n2 = c;
    end else if (rx > uy && rx > fz) begin
      br = rmq_pkg::BR_RX;
      r = 19'(1 << rmq_pkg::FracBits) + 19'(rx) - 19'(uy) - 19'(fz);
      n0 = d; n1 = 17'(fx) + 17'(rz); n2 = a;
    end else if (uy > fz) begin
      br = rmq_pkg::BR_UY;
      r = 19'(1 << rmq_pkg::FracBits) + 19'(uy) - 19'(rx) - 19'(fz);
      n0 = d; n1 = 17'(fy) + 17'(uz); n2 = b;
    end else begin
      br = rmq_pkg::BR_FZ;
      r = 19'(1 << rmq_pkg::FracBits) + 19'(fz) - 19'(rx) - 19'(uy);
      n0 = 17'(fx) + 17'(rz); n1 = 17'(fy) + 17'(uz); n2 = c;
    end
    c_next.branch = br;
    c_next.invalid = (r <= 0);
    c_next.nums[0] = mk(n0);
    c_next.nums[1] = mk(n1);
    c_next.nums[2] = mk(n2);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= in_valid;
    rad <= (r <= 0) ? '0 : r[rmq_pkg::RadW-1:0];
    ctl <= c_next;
  end
endmodule

// ===== rtl/core/rmq_sqrt.sv =====
// Pipelined digit-by-digit square root, one result bit per stage.
module rmq_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [rmq_pkg::RadW-1:0] rad,
  input  rmq_pkg::ctl_t            in_ctl,
  output logic                     out_valid,
  output logic [rmq_pkg::SW-1:0]   root,
  output rmq_pkg::ctl_t            out_ctl
);
  localparam int N = rmq_pkg::SW;
  localparam int OW = 2 * N;

  logic [N:0]              v;
  logic [OW-1:0]           op  [N+1];
  logic [OW+1:0]           rem [N+1];
  logic [N-1:0]            res [N+1];
  rmq_pkg::ctl_t           cs  [N+1];

  logic [OW+1:0]           trial [N];
  logic [OW+1:0]           rsh   [N];

  always_comb begin
    v[0] = in_valid;
    op[0] = OW'({rad, (rmq_pkg::FracBits + 2)'(0)});
    rem[0] = '0;
    res[0] = '0;
    cs[0] = in_ctl;
  end

  // Stage i brings down two operand bits and tries res*4+1.
  for (genvar i = 0; i < N; i++) begin : g_st
    always_comb begin
      rsh[i] = {rem[i][OW-1:0], op[i][OW-1 -: 2]};
      trial[i] = (OW+2)'({res[i], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
      op[i+1] <= op[i] << 2;
      cs[i+1] <= cs[i];
      if (rsh[i] >= trial[i]) begin
        rem[i+1] <= rsh[i] - trial[i];
        res[i+1] <= {res[i][N-2:0], 1'b1};
      end else begin
        rem[i+1] <= rsh[i];
        res[i+1] <= {res[i][N-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v[N];
  assign root = res[N];
  assign out_ctl = cs[N];
endmodule

// ===== rtl/core/rmq_div.sv =====
// Pipelined restoring divider, round half away: q = (mag<<F + s/2) / s.
module rmq_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [rmq_pkg::SW-1:0]   root,
  input  rmq_pkg::ctl_t            in_ctl,
  output logic                     out_valid,
  output logic [rmq_pkg::SW-1:0]   out_root,
  output rmq_pkg::ctl_t            out_ctl,
  output logic [rmq_pkg::QW-1:0]   quo [3]
);
  localparam int N = rmq_pkg::QW;
  localparam int DW = N + 1;   // dividend width after adding s/2

  logic [N:0]             v;
  logic [rmq_pkg::SW-1:0] s   [N+1];
  rmq_pkg::ctl_t          cs  [N+1];
  logic [DW-1:0]          dvd [N+1][3];
  logic [rmq_pkg::SW:0]   rem [N+1][3];
  logic [N-1:0]           q   [N+1][3];

  always_comb begin
    v[0] = in_valid;
    s[0] = (root == '0) ? rmq_pkg::SW'(1) : root;
    cs[0] = in_ctl;
    for (int k = 0; k < 3; k++) begin
      dvd[0][k] = DW'({in_ctl.nums[k].mag, rmq_pkg::FracBits'(0)}) + DW'(root >> 1);
      rem[0][k] = '0;
      q[0][k] = '0;
    end
  end

  // The first dividend bit is always 0 for in-range values; N bits suffice.
  for (genvar i = 0; i < N; i++) begin : g_st
    logic [rmq_pkg::SW+1:0] sh [3];
    always_comb begin
      for (int k = 0; k < 3; k++)
        sh[k] = {rem[i][k], dvd[i][k][DW-2]};
    end
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
      s[i+1] <= s[i];
      cs[i+1] <= cs[i];
      for (int k = 0; k < 3; k++) begin
        dvd[i+1][k] <= dvd[i][k] << 1;
        if (sh[k] >= (rmq_pkg::SW+2)'(s[i])) begin
          rem[i+1][k] <= (rmq_pkg::SW+1)'(sh[k] - (rmq_pkg::SW+2)'(s[i]));
          q[i+1][k] <= {q[i][k][N-2:0], 1'b1};
        end else begin
          rem[i+1][k] <= (rmq_pkg::SW+1)'(sh[k]);
          q[i+1][k] <= {q[i][k][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[N];
  assign out_root = s[N];
  assign out_ctl = cs[N];
  assign quo[0] = q[N][0];
  assign quo[1] = q[N][1];
  assign quo[2] = q[N][2];
endmodule

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// Pipeline from start to done: 1 front, 18 root, 31 divide and 1 output register stage.
// Throughput: one matrix per cycle; busy is always low, the pipeline has no stalls.
// The receiver cannot stall; done pulses one cycle per result.
// Reset clears all valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] right_x, right_y, right_z,
  input  logic signed [15:0] up_x, up_y, up_z,
  input  logic signed [15:0] front_x, front_y, front_z,
  output logic               done,
  output logic signed [15:0] quat_x, quat_y, quat_z, quat_w,
  output logic               invalid
);
  logic                     v1, v2, v3;
  logic [rmq_pkg::RadW-1:0] rad;
  rmq_pkg::ctl_t            c1, c2, c3;
  logic [rmq_pkg::SW-1:0]   root, s3;
  logic [rmq_pkg::QW-1:0]   quo [3];
  logic [15:0]              o [3];
  logic [15:0]              diag;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk, .rst, .in_valid(start),
    .rx(right_x), .ry(right_y), .rz(right_z),
    .ux(up_x), .uy(up_y), .uz(up_z),
    .fx(front_x), .fy(front_y), .fz(front_z),
    .out_valid(v1), .rad, .ctl(c1)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst, .in_valid(v1), .rad, .in_ctl(c1),
    .out_valid(v2), .root, .out_ctl(c2)
  );

  rmq_div u_div (
    .clk, .rst, .in_valid(v2), .root, .in_ctl(c2),
    .out_valid(v3), .out_root(s3), .out_ctl(c3), .quo
  );

  always_comb begin
    diag = 16'((rmq_pkg::SW+1)'(s3) + (rmq_pkg::SW+1)'(2) >> 2);
    for (int k = 0; k < 3; k++) begin
      if (c3.nums[k].neg)
        o[k] = rmq_pkg::sat16(-$signed({2'b00, quo[k]}));
      else
        o[k] = rmq_pkg::sat16($signed({2'b00, quo[k]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v3;
    invalid <= c3.invalid;
    if (c3.invalid) begin
      quat_x <= '0; quat_y <= '0; quat_z <= '0; quat_w <= '0;
    end else begin
      case (c3.branch)
        rmq_pkg::BR_TRACE: begin
          quat_x <= o[0]; quat_y <= o[1]; quat_z <= o[2]; quat_w <= diag;
        end
        rmq_pkg::BR_RX: begin
          quat_x <= diag; quat_y <= o[0]; quat_z <= o[1]; quat_w <= o[2];
        end
        rmq_pkg::BR_UY: begin
          quat_x <= o[0]; quat_y <= diag; quat_z <= o[1]; quat_w <= o[2];
        end
        default: begin
          quat_x <= o[0]; quat_y <= o[1]; quat_z <= diag; quat_w <= o[2];
        end
      endcase
    end
  end
endmodule
